// File: rtl/lir_pkg.sv
`default_nettype none

package lir_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	localparam logic [STEP_W-1:0] STEP_RESET = 18'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_RATIO = 2'd0,
		REG_BYPASS     = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic take;
		logic mul;
		logic rnd;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic bypass;
		logic primed;
		logic pos_ge_one;
		logic last;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/lir_in_if.sv
`default_nettype none

interface lir_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [lir_pkg::SAMPLE_W-1:0] sample_in;
	logic                                block_end;

	modport source (output valid, output sample_in, output block_end, input ready);
	modport sink (input valid, input sample_in, input block_end, output ready);
endinterface

`default_nettype wire

// File: rtl/lir_out_if.sv
`default_nettype none

interface lir_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [lir_pkg::SAMPLE_W-1:0] sample_out;
	logic                                last;

	modport source (output valid, output sample_out, output last, input ready);
	modport sink (input valid, input sample_out, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/lir_cfg_if.sv
`default_nettype none

interface lir_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lir_pkg::CFG_IDX_W-1:0]     index;
	logic [lir_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/linear_interp_resampler.sv
`default_nettype none

// Linear-interpolation sample rate converter producing signed 16-bit samples.
// Each accepted source sample yields zero to MAX_OUTPUTS results; the final one of
// them carries last. Outputs come from one shared multiplier: each result goes through
// multiply, round and clamp, and present, plus any wait on the output side. A new
// sample is taken only once the last result is taken; a sample with no result
// (priming, or a position at or past one) is taken without any of these steps.
// In bypass each sample is returned unchanged as a single result in the cycle after it is taken.
// Configuration writes are always taken and should only be issued while idle.

module linear_interp_resampler #(
	parameter int FRAC_BITS   = 16,
	parameter int MAX_OUTPUTS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lir_in_if.sink     in_ch,
	lir_out_if.source  out_ch,
	lir_cfg_if.sink    cfg_ch
);

	lir_pkg::cmd_t cmd;
	lir_pkg::sts_t sts;

	assign cfg_ch.ready = 1'b1;

	lir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	lir_datapath #(
		.FRAC_BITS   (FRAC_BITS),
		.MAX_OUTPUTS (MAX_OUTPUTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_ch.valid),
		.cfg_idx    (cfg_ch.index),
		.cfg_data   (cfg_ch.data),
		.sample_in  (in_ch.sample_in),
		.cmd        (cmd),
		.sts        (sts),
		.sample_out (out_ch.sample_out),
		.last       (out_ch.last)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input taken while a result is pending");

	a_bypass_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && sts.bypass)
		|=> (out_ch.valid && out_ch.last && out_ch.sample_out == $past(in_ch.sample_in)))
		else $error("bypass request did not pass through");

	a_prime_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && !sts.bypass && !sts.primed)
		|=> (in_ch.ready && !out_ch.valid))
		else $error("priming request produced a result");

endmodule

`default_nettype wire

// File: rtl/lir_datapath.sv
`default_nettype none

module lir_datapath #(
	parameter int FRAC_BITS   = 16,
	parameter int MAX_OUTPUTS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [lir_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [lir_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic signed [lir_pkg::SAMPLE_W-1:0] sample_in,
	input  wire lir_pkg::cmd_t                       cmd,
	output lir_pkg::sts_t                            sts,
	output logic signed [lir_pkg::SAMPLE_W-1:0]      sample_out,
	output logic                                     last
);

	localparam int PW = 4 + FRAC_BITS;
	localparam int AW = (PW > lir_pkg::STEP_W) ? PW : lir_pkg::STEP_W;
	localparam int CW = $clog2(MAX_OUTPUTS + 1);
	localparam int TW = FRAC_BITS + 18;
	localparam int MW = TW - FRAC_BITS;
	localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
	localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);
	localparam logic [MW-1:0] MAG_NEG_LIM = MW'(32768);
	localparam logic [MW-1:0] MAG_POS_LIM = MW'(32767);

	logic [lir_pkg::STEP_W-1:0]          step_q;
	logic                                bypass_q;
	logic                                primed_q;
	logic [PW-1:0]                       pos_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] prev_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] x_q;
	logic [CW-1:0]                       cnt_q;
	logic signed [TW-1:0]                prod_s1;
	logic signed [lir_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                last_q;

	logic                                pos_ge_one;
	logic [AW-1:0]                       pos_sum;
	logic [PW-1:0]                       pos_adv;
	logic [CW-1:0]                       cnt_inc;
	logic                                more;
	logic signed [lir_pkg::SAMPLE_W:0]   diff;
	logic signed [TW-1:0]                prod;
	logic signed [TW-1:0]                total;
	logic                                neg;
	logic [TW-1:0]                       mag;
	logic [TW-1:0]                       mag_rnd;
	logic [MW-1:0]                       rmag;
	logic signed [lir_pkg::SAMPLE_W-1:0] result;

	assign pos_ge_one = (pos_q[PW-1:FRAC_BITS] != '0);
	assign pos_sum    = AW'(pos_q) + AW'(step_q);
	assign pos_adv    = pos_sum[PW-1:0];
	assign cnt_inc    = cnt_q + CW'(1);
	assign more       = (pos_adv[PW-1:FRAC_BITS] == '0) && (cnt_inc < CW'(MAX_OUTPUTS));

	assign diff = {x_q[lir_pkg::SAMPLE_W-1], x_q} - {prev_q[lir_pkg::SAMPLE_W-1], prev_q};
	assign prod = $signed({1'b0, pos_q[FRAC_BITS-1:0]}) * diff;

	assign total   = $signed({{2{prev_q[lir_pkg::SAMPLE_W-1]}}, prev_q, {FRAC_BITS{1'b0}}})
		+ prod_s1;
	assign neg     = total[TW-1];
	assign mag     = neg ? TW'(-total) : TW'(total);
	assign mag_rnd = mag + HALF;
	assign rmag    = mag_rnd[TW-1:FRAC_BITS];

	always_comb begin
		if (neg) begin
			if (rmag > MAG_NEG_LIM) begin
				result = 16'sh8000;
			end else begin
				result = -$signed(rmag[lir_pkg::SAMPLE_W-1:0]);
			end
		end else begin
			if (rmag > MAG_POS_LIM) begin
				result = 16'sh7fff;
			end else begin
				result = $signed(rmag[lir_pkg::SAMPLE_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= lir_pkg::STEP_RESET;
			bypass_q <= 1'b0;
			primed_q <= 1'b0;
			pos_q    <= '0;
			prev_q   <= '0;
			cnt_q    <= '0;
			last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == lir_pkg::CFG_IDX_W'(lir_pkg::REG_STEP_RATIO)) begin
					step_q <= cfg_data[lir_pkg::STEP_W-1:0];
				end else if (cfg_idx == lir_pkg::CFG_IDX_W'(lir_pkg::REG_BYPASS)) begin
					bypass_q <= cfg_data[0];
				end
			end
			if (cmd.take) begin
				cnt_q <= '0;
				if (bypass_q) begin
					last_q <= 1'b1;
				end else if (!primed_q) begin
					prev_q   <= sample_in;
					primed_q <= 1'b1;
				end else if (pos_ge_one) begin
					pos_q  <= pos_q - ONE;
					prev_q <= sample_in;
				end
			end
			if (cmd.rnd) begin
				last_q <= !more;
				pos_q  <= pos_adv;
				cnt_q  <= cnt_inc;
			end
			if (cmd.pop && last_q && !bypass_q) begin
				prev_q <= x_q;
				if (pos_ge_one) begin
					pos_q <= pos_q - ONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q <= sample_in;
			if (bypass_q) begin
				sample_out_q <= sample_in;
			end
		end
		if (cmd.mul) begin
			prod_s1 <= prod;
		end
		if (cmd.rnd) begin
			sample_out_q <= result;
		end
	end

	assign sts.bypass     = bypass_q;
	assign sts.primed     = primed_q;
	assign sts.pos_ge_one = pos_ge_one;
	assign sts.last       = last_q;
	assign sample_out     = sample_out_q;
	assign last           = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_OUTPUTS))
		else $error("output count ran past its limit");

endmodule

`default_nettype wire

// File: rtl/lir_ctrl.sv
`default_nettype none

module lir_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          out_ready,
	input  wire lir_pkg::sts_t sts,
	output logic               in_ready,
	output logic               out_valid,
	output lir_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_RND,
		S_HOLD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;
	logic   out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					priority if (sts.bypass) begin
						state_d = S_HOLD;
					end else if (!sts.primed || sts.pos_ge_one) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				state_d = S_HOLD;
			end
			S_HOLD: begin
				if (out_ready) begin
					cmd.pop = 1'b1;
					state_d = sts.last ? S_IDLE : S_MUL;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			in_ready_q  <= (state_d == S_IDLE);
			out_valid_q <= (state_d == S_HOLD);
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: tb/tb_linear_interp_resampler.sv
`timescale 1ns / 100ps

module tb_linear_interp_resampler;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_OUTPUTS = 16;
	localparam int POS_W       = 4 + FRAC_BITS;

	localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1) << FRAC_BITS;
	localparam longint           UNIT     = 64'sd1 << FRAC_BITS;
	localparam longint           HALF     = UNIT >>> 1;
	localparam int               SAMPLE_MAX = 32767;
	localparam int               SAMPLE_MIN = -32768;

	// Indexes that no register answers to.
	localparam logic [lir_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [lir_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;

	typedef struct {
		logic signed [lir_pkg::SAMPLE_W-1:0] sample;
		logic                                block_end;
	} src_sample_t;

	typedef struct {
		logic signed [lir_pkg::SAMPLE_W-1:0] sample;
		logic                                last;
	} out_sample_t;

	logic clk;
	logic arst_n;

	lir_in_if  in_ch ();
	lir_out_if out_ch ();
	lir_cfg_if cfg_ch ();

	linear_interp_resampler #(
		.FRAC_BITS   (FRAC_BITS),
		.MAX_OUTPUTS (MAX_OUTPUTS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	src_sample_t source_q[$];
	out_sample_t expected_out[$];

	logic [lir_pkg::STEP_W-1:0]          step_q16;
	logic                                bypass_on;
	logic signed [lir_pkg::SAMPLE_W-1:0] held_sample;
	logic [POS_W-1:0]                    read_pos;
	logic                                primed;

	int accepted_items;
	int hold_left;
	int results_checked;
	int errors;
	int settings_used;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic signed [lir_pkg::SAMPLE_W-1:0] blend(
			input logic signed [lir_pkg::SAMPLE_W-1:0] y0,
			input logic signed [lir_pkg::SAMPLE_W-1:0] y1, input logic [POS_W-1:0] frac);
		longint diff;
		longint acc;
		longint rounded;
		diff = longint'(y1) - longint'(y0);
		acc  = longint'(y0) * UNIT + longint'(frac) * diff;
		if (acc >= 0) begin
			rounded = (acc + HALF) >>> FRAC_BITS;
		end else begin
			rounded = -((-acc + HALF) >>> FRAC_BITS);
		end
		if (rounded < SAMPLE_MIN) begin
			rounded = SAMPLE_MIN;
		end
		if (rounded > SAMPLE_MAX) begin
			rounded = SAMPLE_MAX;
		end
		return rounded[lir_pkg::SAMPLE_W-1:0];
	endfunction

	task automatic resample_one(input logic signed [lir_pkg::SAMPLE_W-1:0] x);
		out_sample_t burst[MAX_OUTPUTS];
		out_sample_t single;
		int n;
		n = 0;
		if (bypass_on) begin
			single.sample = x;
			single.last   = 1'b1;
			expected_out.insert(expected_out.size(), single);
			return;
		end
		if (!primed) begin
			held_sample = x;
			primed = 1'b1;
			return;
		end
		while (read_pos < POS_ONE && n < MAX_OUTPUTS) begin
			burst[n].sample = blend(held_sample, x, read_pos);
			burst[n].last = 1'b0;
			n++;
			read_pos = read_pos + POS_W'(step_q16);
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1) begin
				burst[i].last = 1'b1;
			end
			expected_out.insert(expected_out.size(), burst[i]);
		end
		if (read_pos >= POS_ONE) begin
			read_pos = read_pos - POS_ONE;
		end
		held_sample = x;
	endtask

	function automatic logic quiet_window();
		return accepted_items >= 150 && accepted_items < 230;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid     <= 1'b0;
			in_ch.sample_in <= '0;
			in_ch.block_end <= 1'b0;
			accepted_items  <= 0;
			held_sample     = '0;
			read_pos        = '0;
			primed          = 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				resample_one(in_ch.sample_in);
				void'(source_q.pop_front());
				accepted_items <= accepted_items + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (source_q.size() > 0 && (quiet_window() || $urandom_range(99) >= 15)) begin
					in_ch.valid     <= 1'b1;
					in_ch.sample_in <= source_q[0].sample;
					in_ch.block_end <= source_q[0].block_end;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// The output side stops taking results for a long stretch twice, while requests keep coming.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (in_ch.valid && in_ch.ready
				&& (accepted_items == 40 || accepted_items == 280)) begin
			hold_left <= HOLD_CYCLES;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_out.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual sample %0d last %0b",
						$time, out_ch.sample_out, out_ch.last);
					errors++;
				end else begin
					if (out_ch.sample_out !== expected_out[0].sample) begin
						$display("%0t: sample_out mismatch, expected %0d, actual %0d",
							$time, expected_out[0].sample, out_ch.sample_out);
						errors++;
					end
					if (out_ch.last !== expected_out[0].last) begin
						$display("%0t: last mismatch, expected %0b, actual %0b",
							$time, expected_out[0].last, out_ch.last);
						errors++;
					end
					void'(expected_out.pop_front());
				end
				results_checked++;
			end
			out_ch.ready <= hold_left == 0 && (quiet_window() || $urandom_range(99) >= 15);
		end
	end

	task automatic write_reg(input logic [lir_pkg::CFG_IDX_W-1:0] idx,
			input logic [lir_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		unique case (idx)
			lir_pkg::REG_STEP_RATIO: step_q16 = value[lir_pkg::STEP_W-1:0];
			lir_pkg::REG_BYPASS: bypass_on = value[0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic drain();
		while (source_q.size() != 0 || in_ch.valid || expected_out.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send(input int value, input logic block_end);
		src_sample_t item;
		item.sample    = value[lir_pkg::SAMPLE_W-1:0];
		item.block_end = block_end;
		source_q.insert(source_q.size(), item);
	endtask

	function automatic int pick_sample();
		unique case ($urandom_range(19))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return 0;
			3: return int'($urandom_range(8)) - 4;
			default: return int'($signed($urandom() & 32'hFFFF) << 16) >>> 16;
		endcase
	endfunction

	function automatic logic [lir_pkg::STEP_W-1:0] pick_step();
		unique case ($urandom_range(7))
			0: return 18'd60211;
			1: return 18'd10923;
			2: return 18'd30106;
			3: return 18'd131072;
			4: return 18'd4096;
			5: return 18'd262143;
			default: return lir_pkg::STEP_W'($urandom_range(262143, 4096));
		endcase
	endfunction

	initial begin
		arst_n          = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		step_q16        = lir_pkg::STEP_RESET;
		bypass_on       = 1'b0;
		settings_used   = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_reg(REG_SPARE_A, 18'h00123);
		write_reg(REG_SPARE_B, 18'h3FFFF);

		send(SAMPLE_MAX, 1'b0);
		send(SAMPLE_MIN, 1'b1);
		send(SAMPLE_MAX, 1'b0);
		send(0, 1'b1);
		send(SAMPLE_MIN, 1'b0);
		drain();

		// Half a step: exact halves must round away from zero in both directions.
		write_reg(lir_pkg::REG_STEP_RATIO, 18'd32768);
		send(1, 1'b0);
		send(0, 1'b0);
		send(-1, 1'b1);
		send(2, 1'b0);
		drain();

		write_reg(lir_pkg::REG_STEP_RATIO, 18'h3FFFF);
		send(SAMPLE_MAX, 1'b0);
		send(SAMPLE_MIN, 1'b1);
		send(100, 1'b0);
		send(-100, 1'b0);
		send(SAMPLE_MAX, 1'b1);
		drain();

		write_reg(lir_pkg::REG_STEP_RATIO, 18'd4096);
		send(SAMPLE_MIN, 1'b0);
		send(SAMPLE_MAX, 1'b1);
		drain();

		// Steps this small hit the cap on results per request.
		write_reg(lir_pkg::REG_STEP_RATIO, 18'd1000);
		send(-5000, 1'b0);
		send(12345, 1'b0);
		drain();
		write_reg(lir_pkg::REG_STEP_RATIO, 18'd0);
		send(SAMPLE_MAX, 1'b0);
		send(SAMPLE_MIN, 1'b1);
		drain();

		write_reg(lir_pkg::REG_BYPASS, 18'd1);
		send(SAMPLE_MIN, 1'b0);
		send(SAMPLE_MAX, 1'b1);
		send(0, 1'b0);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			write_reg(lir_pkg::REG_BYPASS, ($urandom_range(7) == 0) ? 18'd1 : 18'd0);
			write_reg(lir_pkg::REG_STEP_RATIO, pick_step());
			for (int i = 0; i < 48; i++) begin
				send(pick_sample(), 1'($urandom_range(1)));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d source samples and %0d checked output samples",
			accepted_items, results_checked);
		$display("over %0d register writes, with bypass, ratios from zero to the maximum, %s",
			settings_used, "and two long output stalls.");
		if (errors == 0 && expected_out.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results never seen", errors, expected_out.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding", expected_out.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
